[rtl/core/wvm_pkg.sv]
// Package for the wavetable voice mixer: sizes, field widths, request codes
// and the command and status structs between controller and datapath.
// No dependencies.
package wvm_pkg;

   // Block sizes (table size is a power of two)
   localparam int NUM_VOICES = 10;
   localparam int TABLE_SIZE = 2048;

   // Request and result field widths
   localparam int MODE_W   = 2;
   localparam int VIDX_W   = 4;
   localparam int STEP_W   = 27;
   localparam int PERIOD_W = 16;
   localparam int TIDX_W   = 11;
   localparam int SAMPLE_W = 16;

   // Derived widths
   localparam int FRAC_W  = 16;
   localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int TBL_AW  = $clog2(TABLE_SIZE);

   // Divide by five: floor(x * 52429 / 2^18) is exact for 16-bit x
   localparam int DIV5_MUL   = 52429;
   localparam int DIV5_SHIFT = 18;
   localparam int VOICE_MAX  = 32768 / 5;
   localparam int QUO_W      = $clog2(VOICE_MAX + 1);
   localparam int SUM_RAW_W  = $clog2(NUM_VOICES * (VOICE_MAX + 1)) + 1;
   localparam int SUM_W      = (SUM_RAW_W > SAMPLE_W + 1) ? SUM_RAW_W : SAMPLE_W + 1;

   // Request codes
   localparam logic [MODE_W-1:0] MODE_TICK        = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET_VOICE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE_TABLE = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic               clear_sum;
      logic               issue;
      logic [VOICE_W-1:0] voice;
      logic               set_voice;
      logic               write_table;
      logic               load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pipe_busy;
   } status_type;

endpackage

[rtl/core/wvm_chan_if.sv]
// Valid/ready channel interfaces for the wavetable voice mixer:
// the request channel and the mixed sample channel. No dependencies.
interface wvm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [3:0]         voice_index;
   logic [26:0]        phase_step;
   logic [15:0]        period_length;
   logic               voice_on;
   logic [10:0]        table_index;
   logic signed [15:0] table_value;

   modport source (output valid, mode, voice_index, phase_step, period_length,
                   voice_on, table_index, table_value, input ready);
   modport sink (input valid, mode, voice_index, phase_step, period_length,
                 voice_on, table_index, table_value, output ready);
endinterface

interface wvm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] mixed_sample;

   modport source (output valid, mixed_sample, input ready);
   modport sink (input valid, mixed_sample, output ready);
endinterface

[rtl/core/wavetable_voice_mixer_unit.sv]
// Top level of the wavetable voice mixer: controller plus datapath.
// Depends on wvm_pkg, wvm_chan_if, wvm_ctrl and wvm_datapath.

// Polyphonic wavetable oscillator. A set-voice request or a table-write request
// leaves the block ready again in the next cycle. A tick request sweeps the voices
// one per cycle through a shared five-stage interpolation pipeline (two-port table
// read, slope multiply, truncation, divide by five, accumulate). The sweep then
// waits only for active voices still in the pipeline before it presents the mixed
// sample, and the block is ready for the next request in the same cycle, while the
// sample may still wait in the output register; a sample that is still waiting
// there when the next sweep ends holds that sweep until the sink takes it.
// Inactive voices take their sweep slot but neither sound nor advance. The table
// size is a power of two; table entries read before they are written give
// undefined samples.
module wavetable_voice_mixer_unit (
   input logic        clock,
   input logic        reset,
   wvm_req_if.sink    req_ch,
   wvm_rsp_if.source  rsp_ch
);

   wvm_pkg::cmd_type    cmd;
   wvm_pkg::status_type status;

   wvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wvm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_voice_index   (req_ch.voice_index),
      .req_phase_step    (req_ch.phase_step),
      .req_period_length (req_ch.period_length),
      .req_voice_on      (req_ch.voice_on),
      .req_table_index   (req_ch.table_index),
      .req_table_value   (req_ch.table_value),
      .rsp_mixed_sample  (rsp_ch.mixed_sample)
   );

endmodule

[rtl/core/wvm_ctrl.sv]
// Controller of the wavetable voice mixer: request handshake, voice sweep
// and result handshake. Depends on wvm_pkg.
module wvm_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [wvm_pkg::MODE_W-1:0]      req_mode,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  wvm_pkg::status_type             status,
   output wvm_pkg::cmd_type                cmd
);

   localparam int VOICE_W = wvm_pkg::VOICE_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [VOICE_W-1:0] vcnt_ff, vcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   // Decode requests, sweep the voices, hand off the mixed sample
   always_comb begin
      state_in = state_ff;
      vcnt_in  = vcnt_ff;
      cmd      = '0;
      cmd.voice = vcnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  wvm_pkg::MODE_TICK: begin
                     cmd.clear_sum = 1'b1;
                     vcnt_in       = '0;
                     state_in      = ST_SCAN;
                  end
                  wvm_pkg::MODE_SET_VOICE:   cmd.set_voice   = 1'b1;
                  wvm_pkg::MODE_WRITE_TABLE: cmd.write_table = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (vcnt_ff == VOICE_W'(wvm_pkg::NUM_VOICES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               vcnt_in = vcnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && (!rsp_valid_ff || rsp_ready)) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result until the sink takes it
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcnt_ff      <= vcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/wvm_datapath.sv]
// Datapath of the wavetable voice mixer: sample table, voice registers,
// interpolation pipeline, mix accumulator and result register. Depends on wvm_pkg.
module wvm_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  wvm_pkg::cmd_type                        cmd,
   output wvm_pkg::status_type                     status,
   input  logic [wvm_pkg::VIDX_W-1:0]              req_voice_index,
   input  logic [wvm_pkg::STEP_W-1:0]              req_phase_step,
   input  logic [wvm_pkg::PERIOD_W-1:0]            req_period_length,
   input  logic                                    req_voice_on,
   input  logic [wvm_pkg::TIDX_W-1:0]              req_table_index,
   input  logic signed [wvm_pkg::SAMPLE_W-1:0]     req_table_value,
   output logic signed [wvm_pkg::SAMPLE_W-1:0]     rsp_mixed_sample
);

   localparam int NUM_VOICES = wvm_pkg::NUM_VOICES;
   localparam int TABLE_SIZE = wvm_pkg::TABLE_SIZE;
   localparam int VOICE_W    = wvm_pkg::VOICE_W;
   localparam int TBL_AW     = wvm_pkg::TBL_AW;
   localparam int STEP_W     = wvm_pkg::STEP_W;
   localparam int PERIOD_W   = wvm_pkg::PERIOD_W;
   localparam int FRAC_W     = wvm_pkg::FRAC_W;
   localparam int SAMPLE_W   = wvm_pkg::SAMPLE_W;
   localparam int QUO_W      = wvm_pkg::QUO_W;
   localparam int SUM_W      = wvm_pkg::SUM_W;
   localparam int INT_W      = STEP_W - FRAC_W;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int MAG_W      = SAMPLE_W;
   localparam int DPROD_W    = 32;

   // Voice registers
   logic                active_ff [NUM_VOICES];
   logic [STEP_W-1:0]   step_ff   [NUM_VOICES];
   logic [PERIOD_W-1:0] period_ff [NUM_VOICES];
   logic [PERIOD_W-1:0] pos_ff    [NUM_VOICES];
   logic [STEP_W-1:0]   phase_ff  [NUM_VOICES];

   // Sample table
   logic signed [SAMPLE_W-1:0] tbl_mem [TABLE_SIZE];

   // Pipeline registers
   logic                       v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [SAMPLE_W-1:0] y0_ff, y1_ff, y0_2_ff;
   logic [FRAC_W-1:0]          frac1_ff;
   logic signed [PROD_W-1:0]   prod2_ff;
   logic [MAG_W-1:0]           mag3_ff;
   logic                       neg3_ff, neg4_ff;
   logic [QUO_W-1:0]           quo4_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] mixed_ff, mixed_in;

   // Current voice and its next state
   logic                set_ok, issue_hit, wrap;
   logic [VOICE_W-1:0]  set_idx;
   logic [STEP_W-1:0]   cur_phase, cur_step, phase_in;
   logic [PERIOD_W-1:0] cur_pos, cur_period, pos_inc, pos_in;
   logic [INT_W-1:0]    int_part;
   logic [TBL_AW-1:0]   rd0, rd1, wr_idx;

   assign set_ok    = (32'(req_voice_index) < NUM_VOICES);
   assign set_idx   = VOICE_W'(req_voice_index);
   assign cur_phase = phase_ff[cmd.voice];
   assign cur_step  = step_ff[cmd.voice];
   assign cur_pos   = pos_ff[cmd.voice];
   assign cur_period = period_ff[cmd.voice];
   assign issue_hit = cmd.issue && active_ff[cmd.voice];

   // Advance phase and position, restart at the end of the period
   assign pos_inc  = cur_pos + 1'b1;
   assign wrap     = (pos_inc >= cur_period) || (pos_inc == '0);
   assign phase_in = wrap ? '0 : (cur_phase + cur_step);
   assign pos_in   = wrap ? '0 : pos_inc;

   // Neighboring table addresses, wrapping at the table end
   assign int_part = cur_phase[STEP_W-1:FRAC_W];
   assign rd0      = TBL_AW'(int_part % TABLE_SIZE);
   assign rd1      = (rd0 == TBL_AW'(TABLE_SIZE - 1)) ? '0 : rd0 + 1'b1;
   assign wr_idx   = TBL_AW'(req_table_index % TABLE_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            active_ff[i] <= 1'b0;
            step_ff[i]   <= '0;
            period_ff[i] <= PERIOD_W'(1);
            pos_ff[i]    <= '0;
            phase_ff[i]  <= '0;
         end
      end else if (cmd.set_voice && set_ok) begin
         active_ff[set_idx] <= req_voice_on;
         step_ff[set_idx]   <= req_phase_step;
         period_ff[set_idx] <= req_period_length;
         pos_ff[set_idx]    <= '0;
         phase_ff[set_idx]  <= '0;
      end else if (issue_hit) begin
         pos_ff[cmd.voice]   <= pos_in;
         phase_ff[cmd.voice] <= phase_in;
      end
   end

   // Write the table, read both neighbors
   always_ff @(posedge clock) begin
      if (cmd.write_table) begin
         tbl_mem[wr_idx] <= req_table_value;
      end
      y0_ff <= tbl_mem[rd0];
      y1_ff <= tbl_mem[rd1];
   end

   // Stage 2: slope times fraction
   logic signed [DIFF_W-1:0] diff;
   assign diff = DIFF_W'(y1_ff) - DIFF_W'(y0_ff);

   // Stage 3: interpolate, truncate toward zero, split sign and magnitude
   logic signed [ACC_W-1:0]  acc;
   logic signed [DIFF_W-1:0] interp;
   logic                     acc_neg;
   logic [DIFF_W-1:0]        mag;
   assign acc     = ACC_W'($signed({y0_2_ff, {FRAC_W{1'b0}}})) + ACC_W'(prod2_ff);
   assign acc_neg = acc[ACC_W-1];
   assign interp  = acc[FRAC_W +: DIFF_W] + DIFF_W'(acc_neg && (acc[FRAC_W-1:0] != '0));
   assign mag     = interp[DIFF_W-1] ? DIFF_W'(-interp) : DIFF_W'(interp);

   // Stage 4: divide the magnitude by five
   logic [DPROD_W-1:0] dprod;
   assign dprod = DPROD_W'(mag3_ff) * DPROD_W'(wvm_pkg::DIV5_MUL);

   always_ff @(posedge clock) begin
      frac1_ff <= cur_phase[FRAC_W-1:0];
      prod2_ff <= diff * $signed({1'b0, frac1_ff});
      y0_2_ff  <= y0_ff;
      mag3_ff  <= mag[MAG_W-1:0];
      neg3_ff  <= interp[DIFF_W-1];
      quo4_ff  <= dprod[wvm_pkg::DIV5_SHIFT +: QUO_W];
      neg4_ff  <= neg3_ff;
   end

   // Accumulate the voice contributions
   logic signed [SUM_W-1:0] contrib;
   assign contrib = neg4_ff ? -$signed(SUM_W'(quo4_ff)) : $signed(SUM_W'(quo4_ff));

   always_comb begin
      sum_in = sum_ff;
      if (cmd.clear_sum) begin
         sum_in = '0;
      end else if (v4_ff) begin
         sum_in = sum_ff + contrib;
      end
   end

   // Saturate the sum to the sample range
   logic sat_ok;
   assign sat_ok = (sum_ff[SUM_W-1:SAMPLE_W-1] == '0) || (&sum_ff[SUM_W-1:SAMPLE_W-1]);

   always_comb begin
      mixed_in = mixed_ff;
      if (cmd.load_out) begin
         if (sat_ok) begin
            mixed_in = sum_ff[SAMPLE_W-1:0];
         end else if (sum_ff[SUM_W-1]) begin
            mixed_in = {1'b1, {(SAMPLE_W-1){1'b0}}};
         end else begin
            mixed_in = {1'b0, {(SAMPLE_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      mixed_ff <= mixed_in;
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue_hit;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign status.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign rsp_mixed_sample = mixed_ff;

endmodule

[rtl/core/wvm_checker.sv]
// Port-level assertions for the wavetable voice mixer and the bind that
// attaches them to the top level. Depends on wvm_pkg and the top level.
module wvm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_mixed_sample
);

   // A tick request stalls further requests while the voices are swept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == wvm_pkg::MODE_TICK) |=> !req_ready)
      else $error("request accepted during a voice sweep");

   // Set-voice and table-write requests leave the block ready
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode != wvm_pkg::MODE_TICK) |=> req_ready)
      else $error("non-tick request stalled the request channel");

   // A new mixed sample appears only at the end of a sweep
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("mixed sample raised without a sweep");

   // A stalled mixed sample holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mixed_sample)))
      else $error("stalled mixed sample dropped or changed");

endmodule

bind wavetable_voice_mixer_unit wvm_checker u_wvm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_mode         (req_ch.mode),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_mixed_sample (rsp_ch.mixed_sample)
);
